@@ sv/stuffed_frame_encoder_macros.svh @@
// Assertion macros shared by the encoder modules.
`ifndef STUFFED_FRAME_ENCODER_MACROS_SVH
`define STUFFED_FRAME_ENCODER_MACROS_SVH

// Clocked implication check, off while reset is high.
`define SFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define SFE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ sv/sfe_pkg.sv @@
// Shared constants and the job record passed from front to back.
package sfe_pkg;

  localparam logic [7:0] ESC_BYTE = 8'hDB;
  localparam logic [7:0] ESC_NL   = 8'hDC;
  localparam logic [7:0] ESC_ESC  = 8'hDD;
  localparam logic [7:0] NEWLINE  = 8'h0A;

  localparam logic [7:0] WRITE_COMMAND_RESET = 8'h77;
  localparam int         JOB_DEPTH_DEFAULT   = 2;

  localparam logic REQ_HEADER  = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  // One classified input item. bytes[0] is sent first.
  typedef struct packed {
    logic            err;      // out of sequence, one error result
    logic            hdr;      // header: restarts the running sum
    logic            close;    // append checksum and newline
    logic [1:0]      last_idx; // index of the last raw byte
    logic [3:0][7:0] bytes;
  } job_t;

endpackage

@@ sv/stuffed_frame_encoder.sv @@
// Top level of the byte-stuffed request frame encoder.
// A header item (req_type 0) opens a frame: command, page, address high and
// address low go out on tx_byte, each escaped (0x0A as DB DC, 0xDB as DB DD),
// with an 8-bit running sum over every byte as sent. When the command equals
// the write_command register, page+1 payload items (req_type 1) follow and are
// escaped the same way; the frame then closes with the two's-complement
// checksum (unescaped) and a newline, the newline dropped when the checksum is
// itself 0x0A. An item out of sequence yields one result with seq_error set and
// tx_byte zero, and changes nothing. run_last marks the last result of an item,
// frame_done the byte that completes a frame. Timing: the front end takes one
// item per cycle while its job queue (JOB_DEPTH entries) has room; the back end
// sends one line byte per cycle while its output can load, so its single byte
// sequencer gives 4 to 10 bytes per header, 1 to 4 (typically 1 or 2) per item.
// The output register is refilled in the same cycle it is popped. Write the
// write_command register only while the block is idle; cfg_ready is always high.
module stuffed_frame_encoder
  import sfe_pkg::*;
#(
  parameter int JOB_DEPTH = JOB_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel (write_command)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // input queue side: transaction on push && !full
  input  logic        push,
  output logic        full,
  input  logic        req_type,
  input  logic [7:0]  command,
  input  logic [7:0]  page,
  input  logic [15:0] address,
  input  logic [7:0]  data_byte,
  // result queue side: transaction on pop && !empty
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  tx_byte,
  output logic        run_last,
  output logic        frame_done,
  output logic        seq_error
);

  logic accept;
  job_t new_job;
  job_t head_job;
  logic head_valid;
  logic head_pop;

  assign accept = push && !full;

  // Classify and track write-frame sequence at accept time.
  sfe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .req_type  (req_type),
    .command   (command),
    .page      (page),
    .address   (address),
    .data_byte (data_byte),
    .job       (new_job)
  );

  // Decouples item intake from byte emission.
  sfe_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .wr_job (new_job),
    .full   (full),
    .pop    (head_pop),
    .valid  (head_valid),
    .rd_job (head_job)
  );

  // One line byte per cycle while the output register can load, escaping and checksum.
  sfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (head_valid),
    .job        (head_job),
    .job_pop    (head_pop),
    .pop        (pop),
    .empty      (empty),
    .tx_byte    (tx_byte),
    .run_last   (run_last),
    .frame_done (frame_done),
    .seq_error  (seq_error)
  );

endmodule

@@ sv/sfe_front.sv @@
// Front end: config register, item classification and frame sequence tracking.
`include "stuffed_frame_encoder_macros.svh"

module sfe_front
  import sfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       accept,
  input  logic       req_type,
  input  logic [7:0] command,
  input  logic [7:0] page,
  input  logic [15:0] address,
  input  logic [7:0] data_byte,
  output job_t       job
);

  logic [7:0] write_command;
  logic       write_open;
  logic       write_open_next;
  logic [8:0] payload_left;
  logic [8:0] payload_left_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    job               = '0;
    write_open_next   = write_open;
    payload_left_next = payload_left;
    if ((req_type == REQ_HEADER && write_open) || (req_type == REQ_PAYLOAD && !write_open)) begin
      job.err = 1'b1;
    end else if (req_type == REQ_HEADER) begin
      job.hdr      = 1'b1;
      job.last_idx = 2'd3;
      job.bytes[0] = command;
      job.bytes[1] = page;
      job.bytes[2] = address[15:8];
      job.bytes[3] = address[7:0];
      if (command == write_command) begin
        write_open_next   = 1'b1;
        payload_left_next = {1'b0, page} + 9'd1;
      end else begin
        job.close = 1'b1;
      end
    end else begin
      job.bytes[0]      = data_byte;
      job.last_idx      = 2'd0;
      payload_left_next = payload_left - 9'd1;
      if (payload_left == 9'd1) begin
        job.close         = 1'b1;
        write_open_next   = 1'b0;
        payload_left_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_command <= WRITE_COMMAND_RESET;
      write_open    <= 1'b0;
      payload_left  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        write_command <= cfg_data;
      end
      if (accept) begin
        write_open   <= write_open_next;
        payload_left <= payload_left_next;
      end
    end
  end

  `SFE_ASSERT(a_open_has_count, write_open |-> payload_left != 9'd0, "open write frame with no payload left")
  `SFE_ASSERT(a_closed_no_count, !write_open |-> payload_left == 9'd0, "payload count without open frame")
  `SFE_NEVER(a_count_range, payload_left > 9'd256, "payload count above 256")

endmodule

@@ sv/sfe_queue.sv @@
// Small job queue between front and back.
module sfe_queue
  import sfe_pkg::*;
#(
  parameter int DEPTH = JOB_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wr_job,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t rd_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign full   = (count == CW'(DEPTH));
  assign valid  = (count != '0);
  assign rd_job = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !(pop && valid)) begin
      count_next = count + CW'(1);
    end else if (!push && pop && valid) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && valid) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
    end
  end

endmodule

@@ sv/sfe_back.sv @@
// Back end: byte sequencer with escaping, running sum, checksum and output register.
`include "stuffed_frame_encoder_macros.svh"

module sfe_back
  import sfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] tx_byte,
  output logic       run_last,
  output logic       frame_done,
  output logic       seq_error
);

  localparam logic [1:0] PH_DATA   = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_CHK    = 2'd2;
  localparam logic [1:0] PH_NL     = 2'd3;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [1:0] idx;
  logic [1:0] idx_next;
  logic [7:0] sum;
  logic [7:0] sum_next;
  logic       out_valid;

  logic       ld_ok;
  logic       emit;
  logic       byte_end;
  logic [7:0] raw;
  logic [7:0] sum_base;
  logic [7:0] chk;
  logic [7:0] cur_byte;
  logic       cur_last;
  logic       cur_done;
  logic       cur_err;

  assign ld_ok    = !out_valid || pop;
  assign empty    = !out_valid;
  assign raw      = job.bytes[idx];
  assign sum_base = (phase == PH_DATA && idx == 2'd0 && job.hdr) ? 8'd0 : sum;
  assign chk      = 8'd0 - sum;

  always_comb begin
    emit       = 1'b0;
    byte_end   = 1'b0;
    job_pop    = 1'b0;
    cur_byte   = '0;
    cur_last   = 1'b0;
    cur_done   = 1'b0;
    cur_err    = 1'b0;
    phase_next = phase;
    idx_next   = idx;
    sum_next   = sum;
    if (job_valid && ld_ok) begin
      emit = 1'b1;
      if (job.err) begin
        cur_err  = 1'b1;
        cur_last = 1'b1;
        job_pop  = 1'b1;
      end else begin
        unique case (phase)
          PH_DATA: begin
            if (raw == NEWLINE || raw == ESC_BYTE) begin
              cur_byte   = ESC_BYTE;
              sum_next   = sum_base + ESC_BYTE;
              phase_next = PH_SECOND;
            end else begin
              cur_byte = raw;
              sum_next = sum_base + raw;
              byte_end = 1'b1;
            end
          end
          PH_SECOND: begin
            cur_byte = (raw == NEWLINE) ? ESC_NL : ESC_ESC;
            sum_next = sum + cur_byte;
            byte_end = 1'b1;
          end
          PH_CHK: begin
            cur_byte = chk;
            if (chk == NEWLINE) begin
              cur_done   = 1'b1;
              cur_last   = 1'b1;
              job_pop    = 1'b1;
              phase_next = PH_DATA;
            end else begin
              phase_next = PH_NL;
            end
          end
          PH_NL: begin
            cur_byte   = NEWLINE;
            cur_done   = 1'b1;
            cur_last   = 1'b1;
            job_pop    = 1'b1;
            phase_next = PH_DATA;
          end
          default: phase_next = PH_DATA;
        endcase
        if (byte_end) begin
          if (idx == job.last_idx) begin
            idx_next = '0;
            if (job.close) begin
              phase_next = PH_CHK;
            end else begin
              phase_next = PH_DATA;
              cur_last   = 1'b1;
              job_pop    = 1'b1;
            end
          end else begin
            idx_next   = idx + 2'd1;
            phase_next = PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DATA;
      idx       <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      idx   <= idx_next;
      sum   <= sum_next;
      if (ld_ok) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx_byte    <= cur_byte;
      run_last   <= cur_last;
      frame_done <= cur_done;
      seq_error  <= cur_err;
    end
  end

  `SFE_ASSERT(a_second_is_escape, phase == PH_SECOND |-> job_valid && (raw == NEWLINE || raw == ESC_BYTE), "escape phase without escapable byte")
  `SFE_ASSERT(a_err_result, out_valid && seq_error |-> tx_byte == 8'd0 && run_last && !frame_done, "malformed error result")
  `SFE_ASSERT(a_done_is_last, out_valid && frame_done |-> run_last, "frame end not last result of item")

endmodule
